/* rtl/gtl_pkg.sv */
// ---------------------------------------------------------------------------
// gtl_pkg: shared types, constants and helpers for the grid trilinear lookup
// Formats, command and status codes, node store words and row mapping.
// ---------------------------------------------------------------------------
package gtl_pkg;

  localparam int AXIS_NODE_BITS = 4;
  localparam int COORD_BITS     = 32;
  localparam int FRAC_BITS      = 16;

  localparam int PAR_W      = FRAC_BITS + 2;
  localparam int FW1        = FRAC_BITS + 1;
  localparam int CELL_W     = 4;
  localparam int RV_W       = FW1 + CELL_W;
  localparam int NODE_MAX   = (1 << AXIS_NODE_BITS) - 1;
  localparam int NODE3_W    = 3 * AXIS_NODE_BITS;
  localparam int ROW_BITS   = 3 * (AXIS_NODE_BITS - 1);
  localparam int ROW_W      = (ROW_BITS > 0) ? ROW_BITS : 1;
  localparam int BANK_DEPTH = 1 << ROW_BITS;
  localparam int NUM_BANKS  = 8;
  localparam int TERM_W     = COORD_BITS + 1;
  localparam int SUM_W      = COORD_BITS + 4;
  localparam int PROD_W     = COORD_BITS + FW1 + 1;
  localparam int CFG_IDX_W  = 2;

  typedef logic [AXIS_NODE_BITS-1:0]    node_idx_t;
  typedef logic [CELL_W-1:0]            cell_t;
  typedef logic [FW1-1:0]               frac_t;
  typedef logic [2*FW1-1:0]             wprod_t;
  typedef logic [RV_W-1:0]              rv_t;
  typedef logic [ROW_W-1:0]             row_t;
  typedef logic [NODE3_W-1:0]           node3_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PAR_W-1:0]      par_t;
  typedef logic signed [TERM_W-1:0]     term_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  // weight value 1.0
  localparam frac_t ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_NOGRID  = 2'd2,
    ST_DONE    = 2'd3
  } st_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_I = 2'd0,
    REG_CELLS_J = 2'd1,
    REG_CELLS_K = 2'd2
  } reg_t;

  // one node store word: present mark plus position
  typedef struct packed {
    logic   present;
    coord_t x;
    coord_t y;
    coord_t z;
  } node_word_t;

  // node store write request
  typedef struct packed {
    logic       en;
    logic [2:0] bank;
    row_t       row;
    node_word_t word;
  } store_wr_t;

  // limit a cell count to the node index range
  function automatic cell_t cell_lim(input cell_t c);
    cell_t r;
    r = c;
    if (int'(c) > NODE_MAX) r = cell_t'(NODE_MAX);
    return r;
  endfunction

  // row inside a parity bank: node index with the low bit of each axis dropped
  function automatic row_t bank_row(input node_idx_t i, input node_idx_t j,
                                    input node_idx_t k);
    node3_t acc;
    acc = (node3_t'(i >> 1) << (2 * (AXIS_NODE_BITS - 1))) |
          (node3_t'(j >> 1) << (AXIS_NODE_BITS - 1)) |
          node3_t'(k >> 1);
    return row_t'(acc);
  endfunction

  // saturate a grown sum to the coordinate range
  function automatic coord_t sat(input sum_t s);
    coord_t r;
    if (s[SUM_W-1:COORD_BITS-1] == '0 || s[SUM_W-1:COORD_BITS-1] == '1)
      r = s[COORD_BITS-1:0];
    else if (s[SUM_W-1])
      r = {1'b1, {(COORD_BITS-1){1'b0}}};
    else
      r = {1'b0, {(COORD_BITS-1){1'b1}}};
    return r;
  endfunction

endpackage

/* rtl/gtl_if.sv */
// ---------------------------------------------------------------------------
// gtl_if: request and result channels of the grid trilinear lookup
// Valid/ready handshake with the payload fields of each channel.
// ---------------------------------------------------------------------------
interface gtl_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  gtl_pkg::node_idx_t         node_i;
  gtl_pkg::node_idx_t         node_j;
  gtl_pkg::node_idx_t         node_k;
  gtl_pkg::coord_t            pos_x;
  gtl_pkg::coord_t            pos_y;
  gtl_pkg::coord_t            pos_z;
  gtl_pkg::par_t              par_u;
  gtl_pkg::par_t              par_v;
  gtl_pkg::par_t              par_w;

  modport source (output valid, cmd, node_i, node_j, node_k, pos_x, pos_y, pos_z,
                  par_u, par_v, par_w, input ready);
  modport sink (input valid, cmd, node_i, node_j, node_k, pos_x, pos_y, pos_z,
                par_u, par_v, par_w, output ready);
endinterface

interface gtl_out_if;
  logic            valid;
  logic            ready;
  gtl_pkg::coord_t out_x;
  gtl_pkg::coord_t out_y;
  gtl_pkg::coord_t out_z;
  logic [1:0]      status;

  modport source (output valid, out_x, out_y, out_z, status, input ready);
  modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

/* rtl/gtl_axis_sel.sv */
// ---------------------------------------------------------------------------
// gtl_axis_sel: cell selection on one axis
// Clamps the parameter to [0,1], scales by the cell count, splits into the
// low node of the cell and the fraction inside it.
// ---------------------------------------------------------------------------
module gtl_axis_sel (
  input  gtl_pkg::par_t  par,
  input  gtl_pkg::cell_t cells,
  output gtl_pkg::cell_t lo,
  output gtl_pkg::frac_t frac
);

  gtl_pkg::frac_t p;
  gtl_pkg::rv_t   real_v;
  logic [gtl_pkg::CELL_W:0] low_raw;
  gtl_pkg::cell_t low;

  // clamp to [0, 1]
  always_comb begin
    if (par < 0)
      p = '0;
    else if (par > $signed({1'b0, gtl_pkg::ONE_Q}))
      p = gtl_pkg::ONE_Q;
    else
      p = par[gtl_pkg::FW1-1:0];
  end

  // scale, floor, limit to the last cell
  always_comb begin
    real_v  = gtl_pkg::rv_t'(p) * gtl_pkg::rv_t'(cells);
    low_raw = real_v[gtl_pkg::RV_W-1:gtl_pkg::FRAC_BITS];
    if (low_raw >= {1'b0, cells})
      low = cells - 1'b1;
    else
      low = low_raw[gtl_pkg::CELL_W-1:0];
  end

  assign lo   = low;
  assign frac = gtl_pkg::frac_t'(real_v - (gtl_pkg::rv_t'(low) << gtl_pkg::FRAC_BITS));

endmodule

/* rtl/gtl_node_store.sv */
// ---------------------------------------------------------------------------
// gtl_node_store: parity-banked node store
// Eight banks split by the low bit of i, j and k, so the eight corners of a
// cell fall in eight different banks. Clearing pass resets present marks.
// ---------------------------------------------------------------------------
module gtl_node_store (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear_start,
  input  logic                rd_en,
  input  gtl_pkg::row_t       rd_row [gtl_pkg::NUM_BANKS],
  input  gtl_pkg::store_wr_t  wr,
  output gtl_pkg::node_word_t rd_data [gtl_pkg::NUM_BANKS],
  output logic                sweeping
);

  gtl_pkg::row_t sweep_row;

  // clearing pass: one row of every bank per cycle
  always_ff @(posedge clk) begin
    if (rst || clear_start) begin
      sweeping  <= 1'b1;
      sweep_row <= '0;
    end else if (sweeping) begin
      if (sweep_row == gtl_pkg::row_t'(gtl_pkg::BANK_DEPTH - 1)) sweeping <= 1'b0;
      sweep_row <= sweep_row + 1'b1;
    end
  end

  for (genvar b = 0; b < gtl_pkg::NUM_BANKS; b++) begin : g_bank
    gtl_pkg::node_word_t mem [gtl_pkg::BANK_DEPTH];
    gtl_pkg::node_word_t q;

    // one write port, one registered read port
    always_ff @(posedge clk) begin
      if (sweeping)
        mem[sweep_row] <= '0;
      else if (wr.en && wr.bank == 3'(b))
        mem[wr.row] <= wr.word;
      if (rd_en) q <= mem[rd_row[b]];
    end

    assign rd_data[b] = q;
  end

endmodule

/* rtl/grid_trilinear_lookup.sv */
// ---------------------------------------------------------------------------
// grid_trilinear_lookup: trilinear blend over a structured 3D node grid
// Pipeline: 5 stages (A to E); the result is registered in stage E.
// Throughput: one request per cycle while the result is taken and no sweep runs; set by the 8-bank node store port.
// A clear holds the input while the store sweeps all BANK_DEPTH (512) rows.
// Reset: synchronous; the same sweep runs, requests wait in stage A.
// ---------------------------------------------------------------------------
module grid_trilinear_lookup (
  input  logic                              clk,
  input  logic                              rst,
  gtl_in_if.sink                            item,
  gtl_out_if.source                         result,
  input  logic                              cfg_we,
  input  logic [gtl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  gtl_pkg::cell_t                    cfg_data
);

  localparam int NB = gtl_pkg::NUM_BANKS;

  // configuration
  gtl_pkg::cell_t cells_i, cells_j, cells_k;
  gtl_pkg::cell_t ci, cj, ck;

  // pipeline control
  logic free_a, free_b, free_c, free_d, free_e, pass_a;
  logic sweeping, clear_start, any_written, nogrid;

  // stage A
  logic               a_valid;
  logic [1:0]         a_cmd;
  gtl_pkg::node_idx_t a_ni, a_nj, a_nk;
  gtl_pkg::coord_t    a_x, a_y, a_z;
  gtl_pkg::cell_t     a_lo [3];
  gtl_pkg::frac_t     a_t [3];
  gtl_pkg::cell_t     sel_lo [3];
  gtl_pkg::frac_t     sel_t [3];

  gtl_pkg::frac_t     a_m [3];
  gtl_pkg::wprod_t    ab_prod [4];
  gtl_pkg::frac_t     ab [4];
  logic [2:0]         a_par;
  gtl_pkg::node_idx_t base_i, base_j, base_k;
  gtl_pkg::row_t      corner_row [NB];
  gtl_pkg::row_t      rd_row [NB];
  gtl_pkg::store_wr_t wr;
  gtl_pkg::st_t       a_status;

  // stage B
  logic                b_valid;
  gtl_pkg::st_t        b_status;
  gtl_pkg::frac_t      b_ab [4];
  gtl_pkg::frac_t      b_tk, b_mk;
  logic [2:0]          b_par;
  gtl_pkg::node_word_t bank_q [NB];
  gtl_pkg::node_word_t corner [NB];
  gtl_pkg::wprod_t     w_prod [NB];
  logic                all_present;
  gtl_pkg::st_t        bc_status;

  // stage C
  logic            c_valid;
  gtl_pkg::st_t    c_status;
  gtl_pkg::frac_t  c_wt [NB];
  gtl_pkg::coord_t c_px [NB];
  gtl_pkg::coord_t c_py [NB];
  gtl_pkg::coord_t c_pz [NB];
  logic signed [gtl_pkg::FW1:0] ws [NB];
  gtl_pkg::prod_t  px_prod [NB];
  gtl_pkg::prod_t  py_prod [NB];
  gtl_pkg::prod_t  pz_prod [NB];

  // stage D
  logic           d_valid;
  gtl_pkg::st_t   d_status;
  gtl_pkg::term_t d_tx [NB];
  gtl_pkg::term_t d_ty [NB];
  gtl_pkg::term_t d_tz [NB];
  gtl_pkg::sum_t  sx, sy, sz;

  // stage E (output register)
  logic            e_valid;
  gtl_pkg::coord_t e_x, e_y, e_z;
  logic [1:0]      e_status;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_i <= '0;
      cells_j <= '0;
      cells_k <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gtl_pkg::REG_CELLS_I: cells_i <= cfg_data;
        gtl_pkg::REG_CELLS_J: cells_j <= cfg_data;
        gtl_pkg::REG_CELLS_K: cells_k <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ci = gtl_pkg::cell_lim(cells_i);
  assign cj = gtl_pkg::cell_lim(cells_j);
  assign ck = gtl_pkg::cell_lim(cells_k);

  // stall chain from the output back
  assign free_e = !e_valid || result.ready;
  assign free_d = !d_valid || free_e;
  assign free_c = !c_valid || free_d;
  assign free_b = !b_valid || free_c;
  assign pass_a = free_b && !sweeping;
  assign free_a = !a_valid || pass_a;
  assign item.ready = free_a;

  assign clear_start = item.valid && free_a && item.cmd == gtl_pkg::CMD_CLEAR;

  // any node written since the last clear
  always_ff @(posedge clk) begin
    if (rst || clear_start)
      any_written <= 1'b0;
    else if (wr.en)
      any_written <= 1'b1;
  end

  // cell selection ahead of stage A
  gtl_axis_sel u_sel_i (.par(item.par_u), .cells(ci), .lo(sel_lo[0]), .frac(sel_t[0]));
  gtl_axis_sel u_sel_j (.par(item.par_v), .cells(cj), .lo(sel_lo[1]), .frac(sel_t[1]));
  gtl_axis_sel u_sel_k (.par(item.par_w), .cells(ck), .lo(sel_lo[2]), .frac(sel_t[2]));

  // stage A
  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (free_a) a_valid <= item.valid;
  end

  always_ff @(posedge clk) begin
    if (free_a) begin
      a_cmd <= item.cmd;
      a_ni  <= item.node_i;
      a_nj  <= item.node_j;
      a_nk  <= item.node_k;
      a_x   <= item.pos_x;
      a_y   <= item.pos_y;
      a_z   <= item.pos_z;
      a_lo  <= sel_lo;
      a_t   <= sel_t;
    end
  end

  // corner rows, bank addresses and store write
  assign nogrid = cells_i == '0 || cells_j == '0 || cells_k == '0 || !any_written;
  assign a_par  = {a_lo[2][0], a_lo[1][0], a_lo[0][0]};
  assign base_i = gtl_pkg::node_idx_t'(a_lo[0]);
  assign base_j = gtl_pkg::node_idx_t'(a_lo[1]);
  assign base_k = gtl_pkg::node_idx_t'(a_lo[2]);

  always_comb begin
    for (int c = 0; c < NB; c++) begin
      corner_row[c] = gtl_pkg::bank_row(base_i + gtl_pkg::node_idx_t'(c & 1),
                                        base_j + gtl_pkg::node_idx_t'((c >> 1) & 1),
                                        base_k + gtl_pkg::node_idx_t'((c >> 2) & 1));
    end
    for (int b = 0; b < NB; b++) begin
      rd_row[b] = corner_row[3'(b) ^ a_par];
    end
  end

  always_comb begin
    wr.en           = a_valid && a_cmd == gtl_pkg::CMD_WRITE && pass_a;
    wr.bank         = {a_nk[0], a_nj[0], a_ni[0]};
    wr.row          = gtl_pkg::bank_row(a_ni, a_nj, a_nk);
    wr.word.present = 1'b1;
    wr.word.x       = a_x;
    wr.word.y       = a_y;
    wr.word.z       = a_z;
  end

  always_comb begin
    case (a_cmd)
      gtl_pkg::CMD_QUERY: a_status = nogrid ? gtl_pkg::ST_NOGRID : gtl_pkg::ST_OK;
      default:            a_status = gtl_pkg::ST_DONE;
    endcase
  end

  // i/j weight products
  always_comb begin
    for (int a = 0; a < 3; a++) a_m[a] = gtl_pkg::ONE_Q - a_t[a];
    for (int p = 0; p < 4; p++) begin
      ab_prod[p] = gtl_pkg::wprod_t'((p & 1) != 0 ? a_t[0] : a_m[0]) *
                   gtl_pkg::wprod_t'((p & 2) != 0 ? a_t[1] : a_m[1]);
      ab[p] = ab_prod[p][gtl_pkg::FRAC_BITS +: gtl_pkg::FW1];
    end
  end

  gtl_node_store u_store (
    .clk        (clk),
    .rst        (rst),
    .clear_start(clear_start),
    .rd_en      (free_b),
    .rd_row     (rd_row),
    .wr         (wr),
    .rd_data    (bank_q),
    .sweeping   (sweeping)
  );

  // stage B
  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (free_b) b_valid <= a_valid && !sweeping;
  end

  always_ff @(posedge clk) begin
    if (free_b) begin
      b_status <= a_status;
      b_ab     <= ab;
      b_tk     <= a_t[2];
      b_mk     <= a_m[2];
      b_par    <= a_par;
    end
  end

  // corner routing, presence check, full weights
  always_comb begin
    all_present = 1'b1;
    for (int c = 0; c < NB; c++) begin
      corner[c]   = bank_q[3'(c) ^ b_par];
      all_present = all_present & corner[c].present;
      w_prod[c]   = gtl_pkg::wprod_t'(b_ab[c & 3]) *
                    gtl_pkg::wprod_t'((c & 4) != 0 ? b_tk : b_mk);
    end
    if (b_status == gtl_pkg::ST_OK && !all_present)
      bc_status = gtl_pkg::ST_MISSING;
    else
      bc_status = b_status;
  end

  // stage C
  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (free_c) c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (free_c) begin
      c_status <= bc_status;
      for (int c = 0; c < NB; c++) begin
        c_wt[c] <= w_prod[c][gtl_pkg::FRAC_BITS +: gtl_pkg::FW1];
        c_px[c] <= corner[c].x;
        c_py[c] <= corner[c].y;
        c_pz[c] <= corner[c].z;
      end
    end
  end

  // weighted terms, floor of p*w / 2^F
  always_comb begin
    for (int c = 0; c < NB; c++) begin
      ws[c]      = {1'b0, c_wt[c]};
      px_prod[c] = c_px[c] * ws[c];
      py_prod[c] = c_py[c] * ws[c];
      pz_prod[c] = c_pz[c] * ws[c];
    end
  end

  // stage D
  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else if (free_d) d_valid <= c_valid;
  end

  always_ff @(posedge clk) begin
    if (free_d) begin
      d_status <= c_status;
      for (int c = 0; c < NB; c++) begin
        d_tx[c] <= px_prod[c][gtl_pkg::FRAC_BITS +: gtl_pkg::TERM_W];
        d_ty[c] <= py_prod[c][gtl_pkg::FRAC_BITS +: gtl_pkg::TERM_W];
        d_tz[c] <= pz_prod[c][gtl_pkg::FRAC_BITS +: gtl_pkg::TERM_W];
      end
    end
  end

  // corner sums
  always_comb begin
    sx = '0;
    sy = '0;
    sz = '0;
    for (int c = 0; c < NB; c++) begin
      sx = sx + gtl_pkg::sum_t'(d_tx[c]);
      sy = sy + gtl_pkg::sum_t'(d_ty[c]);
      sz = sz + gtl_pkg::sum_t'(d_tz[c]);
    end
  end

  // stage E: saturate, zero unless interpolated
  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else if (free_e) e_valid <= d_valid;
  end

  always_ff @(posedge clk) begin
    if (free_e) begin
      e_status <= d_status;
      if (d_status == gtl_pkg::ST_OK) begin
        e_x <= gtl_pkg::sat(sx);
        e_y <= gtl_pkg::sat(sy);
        e_z <= gtl_pkg::sat(sz);
      end else begin
        e_x <= '0;
        e_y <= '0;
        e_z <= '0;
      end
    end
  end

  assign result.valid  = e_valid;
  assign result.out_x  = e_x;
  assign result.out_y  = e_y;
  assign result.out_z  = e_z;
  assign result.status = e_status;

endmodule

/* rtl/gtl_check.sv */
// ---------------------------------------------------------------------------
// gtl_check: port-level checks for the grid trilinear lookup
// Bound to the top level; watches the request and result channels.
// ---------------------------------------------------------------------------
module gtl_check (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic [1:0]      in_cmd,
  input logic            out_valid,
  input logic            out_ready,
  input gtl_pkg::coord_t out_x,
  input gtl_pkg::coord_t out_y,
  input gtl_pkg::coord_t out_z,
  input logic [1:0]      out_status
);

  // a clear holds off the next request while the store sweeps
  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd == gtl_pkg::CMD_CLEAR |=> !in_ready)
    else $error("request taken right after a clear");

  // only interpolated results carry coordinates
  a_zero_coords: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != gtl_pkg::ST_OK |->
      out_x == '0 && out_y == '0 && out_z == '0)
    else $error("nonzero coordinates on a non-interpolated result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) &&
      $stable(out_status))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind grid_trilinear_lookup gtl_check u_gtl_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .in_cmd    (item.cmd),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_x     (result.out_x),
  .out_y     (result.out_y),
  .out_z     (result.out_z),
  .out_status(result.status)
);

/* tb/sv/gtl_tb_pkg.sv */
// ---------------------------------------------------------------------------
// gtl_tb_pkg: grid model and result scoreboard for the trilinear lookup bench
// Keeps a private copy of the node grid and cell counts, computes the result
// of every accepted request and checks the block's results in order.
// ---------------------------------------------------------------------------
package gtl_tb_pkg;

  typedef struct {
    logic [1:0] cmd;
    logic [3:0] ni, nj, nk;
    logic signed [31:0] px, py, pz;
    logic signed [17:0] pu, pv, pw;
  } grid_req_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [1:0] status;
  } grid_res_t;

  class grid_scoreboard;
    logic signed [31:0] pos_x[4096], pos_y[4096], pos_z[4096];
    bit present[4096];
    int fill;
    int cells[3];
    grid_res_t pending[$];
    int mismatches;
    int checked;
    int n_ok, n_missing, n_nogrid, n_done;

    function new();
      fill = 0;
      mismatches = 0;
      checked = 0;
      foreach (present[n]) present[n] = 0;
      foreach (cells[a]) cells[a] = 0;
    endfunction

    function void set_cells(int axis, int val);
      cells[axis] = val;
    endfunction

    function logic signed [31:0] clip(longint s);
      if (s > 64'sd2147483647) return 32'h7fffffff;
      if (s < -64'sd2147483648) return 32'h80000000;
      return s[31:0];
    endfunction

    // pick the low node on one axis and its fraction
    function void axis_cell(logic signed [17:0] par, int cnt, output int low,
                            output longint frac);
      longint p, prod;
      p = par;
      if (p < 0) p = 0;
      if (p > 65536) p = 65536;
      prod = p * cnt;
      low = int'(prod >>> 16);
      if (low >= cnt) low = cnt - 1;
      frac = prod - (longint'(low) <<< 16);
    endfunction

    // note an accepted request and compute its result
    function void note_request(grid_req_t r);
      grid_res_t e;
      int n, c, lo[3], cl[3];
      longint t[3], m[3], a, b, d, wt;
      longint sx, sy, sz;
      bit all;
      e.x = 0; e.y = 0; e.z = 0;
      e.status = gtl_pkg::ST_DONE;
      case (r.cmd)
        gtl_pkg::CMD_CLEAR: begin
          foreach (present[q]) present[q] = 0;
          fill = 0;
        end
        gtl_pkg::CMD_WRITE: begin
          n = int'({r.ni, r.nj, r.nk});
          pos_x[n] = r.px; pos_y[n] = r.py; pos_z[n] = r.pz;
          if (!present[n]) begin
            present[n] = 1;
            if (fill < 8191) fill++;
          end
        end
        gtl_pkg::CMD_QUERY: begin
          for (c = 0; c < 3; c++) cl[c] = (cells[c] > 15) ? 15 : cells[c];
          if (cl[0] == 0 || cl[1] == 0 || cl[2] == 0 || fill == 0) begin
            e.status = gtl_pkg::ST_NOGRID;
          end else begin
            axis_cell(r.pu, cl[0], lo[0], t[0]);
            axis_cell(r.pv, cl[1], lo[1], t[1]);
            axis_cell(r.pw, cl[2], lo[2], t[2]);
            for (c = 0; c < 3; c++) m[c] = 65536 - t[c];
            all = 1;
            sx = 0; sy = 0; sz = 0;
            for (c = 0; c < 8; c++) begin
              a = c[0] ? t[0] : m[0];
              b = c[1] ? t[1] : m[1];
              d = c[2] ? t[2] : m[2];
              n = ((lo[0] + c[0]) << 8) | ((lo[1] + c[1]) << 4) | (lo[2] + c[2]);
              wt = (((a * b) >>> 16) * d) >>> 16;
              if (!present[n]) all = 0;
              else begin
                // floor(p*w/2^16) with a 64-bit signed product is exact here
                sx += (longint'(pos_x[n]) * wt) >>> 16;
                sy += (longint'(pos_y[n]) * wt) >>> 16;
                sz += (longint'(pos_z[n]) * wt) >>> 16;
              end
            end
            if (!all) e.status = gtl_pkg::ST_MISSING;
            else begin
              e.status = gtl_pkg::ST_OK;
              e.x = clip(sx); e.y = clip(sy); e.z = clip(sz);
            end
          end
        end
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(grid_res_t g);
      grid_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result status=%0d x=%0d", g.status, g.x);
        return;
      end
      e = pending.pop_front();
      checked++;
      case (e.status)
        gtl_pkg::ST_OK: n_ok++;
        gtl_pkg::ST_MISSING: n_missing++;
        gtl_pkg::ST_NOGRID: n_nogrid++;
        default: n_done++;
      endcase
      if (g.x !== e.x || g.y !== e.y || g.z !== e.z || g.status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: exp st=%0d (%0d,%0d,%0d) got st=%0d (%0d,%0d,%0d)",
                   checked, e.status, e.x, e.y, e.z, g.status, g.x, g.y, g.z);
      end
    endfunction
  endclass
endpackage

/* tb/sv/testbench.sv */
// ---------------------------------------------------------------------------
// testbench: grid_trilinear_lookup bench
// Directed and random clears, node writes and queries under several idle
// and stall mixes and several cell-count settings; results are checked
// against a private grid model.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [gtl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  gtl_pkg::cell_t cfg_data = '0;

  gtl_in_if item ();
  gtl_out_if result ();

  grid_trilinear_lookup dut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  gtl_tb_pkg::grid_scoreboard grid_sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_off = 0;
  int idle_cycles = 0;
  int sent = 0;

  initial begin
    item.valid = 0; item.cmd = '0; item.node_i = '0; item.node_j = '0;
    item.node_k = '0; item.pos_x = '0; item.pos_y = '0; item.pos_z = '0;
    item.par_u = '0; item.par_v = '0; item.par_w = '0;
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= 300;
      result.ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      result.ready <= 0;
    end else begin
      result.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checking
  always @(posedge clk) begin
    gtl_tb_pkg::grid_res_t g;
    if (!rst && result.valid && result.ready) begin
      g.x = result.out_x; g.y = result.out_y; g.z = result.out_z;
      g.status = result.status;
      grid_sb.check_result(g);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((item.valid && item.ready) || (result.valid && result.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("ERROR: watchdog expired");
      $display("** grid_trilinear_lookup: FAILED **");
      $finish;
    end
  end

  // send one request, with a random idle gap first
  task automatic send(gtl_tb_pkg::grid_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      item.valid <= 0;
      @(posedge clk);
    end
    item.valid <= 1; item.cmd <= r.cmd;
    item.node_i <= r.ni; item.node_j <= r.nj; item.node_k <= r.nk;
    item.pos_x <= r.px; item.pos_y <= r.py; item.pos_z <= r.pz;
    item.par_u <= r.pu; item.par_v <= r.pv; item.par_w <= r.pw;
    do @(posedge clk); while (!item.ready);
    grid_sb.note_request(r);
    sent++;
  endtask

  task automatic drop_valid();
    item.valid <= 0;
  endtask

  // block is idle once all results are back and the pipe has drained
  task automatic drain();
    drop_valid();
    while (grid_sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(gtl_pkg::reg_t idx, int val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= gtl_pkg::cell_t'(val);
    @(posedge clk);
    cfg_we <= 0;
    grid_sb.set_cells(int'(idx), val);
  endtask

  task automatic set_grid(int ci, int cj, int ck);
    write_cfg(gtl_pkg::REG_CELLS_I, ci);
    write_cfg(gtl_pkg::REG_CELLS_J, cj);
    write_cfg(gtl_pkg::REG_CELLS_K, ck);
    @(posedge clk);
  endtask

  function automatic gtl_tb_pkg::grid_req_t mk(logic [1:0] cmd);
    gtl_tb_pkg::grid_req_t r;
    r.cmd = cmd;
    r.ni = 4'($urandom); r.nj = 4'($urandom); r.nk = 4'($urandom);
    r.px = $urandom; r.py = $urandom; r.pz = $urandom;
    r.pu = 18'($urandom); r.pv = 18'($urandom); r.pw = 18'($urandom);
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff - $urandom_range(3);
      1: return 32'h80000000 + $urandom_range(3);
      2: return $urandom;
      default: return $signed($urandom_range(4000000)) - 2000000;
    endcase
  endfunction

  function automatic logic signed [17:0] rnd_par();
    case ($urandom_range(7))
      0: return 18'sd65536;
      1: return 18'sd0;
      2: return 18'($urandom);
      default: return 18'($urandom_range(65536));
    endcase
  endfunction

  // write every node of the current grid
  task automatic fill_grid(int ci, int cj, int ck);
    gtl_tb_pkg::grid_req_t r;
    for (int i = 0; i <= ci; i++)
      for (int j = 0; j <= cj; j++)
        for (int k = 0; k <= ck; k++) begin
          r = mk(gtl_pkg::CMD_WRITE);
          r.ni = 4'(i); r.nj = 4'(j); r.nk = 4'(k);
          r.px = rnd_coord(); r.py = rnd_coord(); r.pz = rnd_coord();
          send(r);
        end
  endtask

  task automatic random_phase(int n);
    gtl_tb_pkg::grid_req_t r;
    for (int q = 0; q < n; q++) begin
      case ($urandom_range(19))
        0: r = mk($urandom_range(1) ? gtl_pkg::CMD_CLEAR : gtl_pkg::CMD_RSVD);
        1, 2, 3, 4: begin
          r = mk(gtl_pkg::CMD_WRITE);
          r.ni = 4'($urandom_range(grid_sb.cells[0]));
          r.nj = 4'($urandom_range(grid_sb.cells[1]));
          r.nk = 4'($urandom_range(grid_sb.cells[2]));
          r.px = rnd_coord(); r.py = rnd_coord(); r.pz = rnd_coord();
        end
        5: r = mk(gtl_pkg::CMD_WRITE);
        default: begin
          r = mk(gtl_pkg::CMD_QUERY);
          r.pu = rnd_par(); r.pv = rnd_par(); r.pw = rnd_par();
        end
      endcase
      send(r);
    end
  endtask

  initial begin
    gtl_tb_pkg::grid_req_t r;
    int g[3];
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: no grid, unused command, clear, extremes
    r = mk(gtl_pkg::CMD_QUERY); send(r);
    r = mk(gtl_pkg::CMD_RSVD); send(r);
    drain();
    set_grid(0, 0, 0);
    r = mk(gtl_pkg::CMD_WRITE); r.ni = 4'd0; r.nj = 4'd0; r.nk = 4'd0; send(r);
    r = mk(gtl_pkg::CMD_QUERY); send(r);
    drain();
    set_grid(1, 1, 1);
    r = mk(gtl_pkg::CMD_QUERY); r.pu = 18'sd0; r.pv = 18'sd0; r.pw = 18'sd0; send(r);
    fill_grid(1, 1, 1);
    r = mk(gtl_pkg::CMD_WRITE); r.ni = 4'd1; r.nj = 4'd1; r.nk = 4'd1;
    r.px = 32'h7fffffff; r.py = 32'h80000000; r.pz = 32'hffffffff; send(r);
    r = mk(gtl_pkg::CMD_QUERY); r.pu = 18'h1ffff; r.pv = 18'h20000; r.pw = 18'sd65536;
    send(r);
    r = mk(gtl_pkg::CMD_QUERY); r.pu = 18'sd32768; r.pv = 18'sd32768; r.pw = 18'sd32768;
    send(r);
    r = mk(gtl_pkg::CMD_QUERY); r.pu = 18'h3ffff; r.pv = 18'sd1; r.pw = 18'sd65535;
    send(r);
    r = mk(gtl_pkg::CMD_CLEAR); send(r);
    r = mk(gtl_pkg::CMD_QUERY); send(r);
    r = mk(gtl_pkg::CMD_WRITE); r.ni = 4'd15; r.nj = 4'd15; r.nk = 4'd15; send(r);
    r = mk(gtl_pkg::CMD_QUERY); r.pu = 18'sd0; send(r);
    drain();

    // random phases under several grids and idle mixes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin g = '{15, 15, 15}; send_idle_pct = 0; stall_pct = 0; end
        1: begin g = '{2, 3, 1}; send_idle_pct = 79; stall_pct = 0; end
        2: begin g = '{1, 1, 2}; send_idle_pct = 0; stall_pct = 79; end
        3: begin g = '{3, 2, 2}; send_idle_pct = 35; stall_pct = 35; end
        4: begin g = '{4, 1, 3}; send_idle_pct = 0; stall_pct = 10; end
        default: begin g = '{2, 2, 2}; send_idle_pct = 20; stall_pct = 20; end
      endcase
      set_grid(g[0], g[1], g[2]);
      if (ph == 0) begin
        // largest grid: sparse writes plus queries at the far corner
        for (int q = 0; q < 40; q++) begin
          r = mk(gtl_pkg::CMD_WRITE); r.ni = 4'(14 + $urandom_range(1));
          r.nj = 4'(14 + $urandom_range(1)); r.nk = 4'(14 + $urandom_range(1)); send(r);
          r = mk(gtl_pkg::CMD_QUERY); r.pu = 18'(65536 - $urandom_range(3000));
          r.pv = 18'(65536 - $urandom_range(3000));
          r.pw = 18'(65536 - $urandom_range(3000)); send(r);
        end
      end else begin
        r = mk(gtl_pkg::CMD_CLEAR); send(r);
        fill_grid(g[0], g[1], g[2]);
        if (ph == 4) begin
          hold_req = hold_req + 1;
          random_phase(60);
        end
        random_phase(190);
      end
      drain();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests: %0d interpolated, %0d missing corner, %0d no grid,",
             sent, grid_sb.n_ok, grid_sb.n_missing, grid_sb.n_nogrid);
    $display("  %0d clear/write/unused, grids from 1x1x1 to 15x15x15; %0d mismatches",
             grid_sb.n_done, grid_sb.mismatches);
    if (grid_sb.mismatches == 0 && grid_sb.pending.size() == 0)
      $display("** grid_trilinear_lookup: PASSED **");
    else
      $display("** grid_trilinear_lookup: FAILED **");
    $finish;
  end
endmodule
